>>> rtl/core/lfgr_pkg.sv
// ----------------------------------------------------------------------------
// lfgr_pkg
// Shared constants and types for the gap-closed frame receiver: item kind
// codes, register indexes, protocol bytes and the result beat layout.
// ----------------------------------------------------------------------------
`default_nettype none

package lfgr_pkg;

  // Item kind carried by the func field of an input request.
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Register indexes, taken from the word address bit of the config port.
  localparam logic REG_EXPECTED_ID   = 1'b0;
  localparam logic REG_GAP_THRESHOLD = 1'b1;

  // Protocol constants.
  localparam logic [7:0]  SYNC_BYTE     = 8'h55;
  localparam logic [15:0] GAP_RESET     = 16'd650;
  localparam logic [15:0] IDLE_MAX      = 16'hFFFF;
  localparam int          MIN_FRAME_LEN = 2;

  // One result beat as it leaves the block.
  typedef struct packed {
    logic [7:0] frame_byte;
    logic [3:0] byte_index;
    logic [3:0] frame_length;
    logic       last;
  } out_beat_t;

endpackage

`default_nettype wire

>>> rtl/core/lfgr_store.sv
// ----------------------------------------------------------------------------
// lfgr_store
// Frame byte store: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lfgr_store #(
  parameter int MAX_FRAME_BYTES = 11
) (
  input  wire logic                               clk,
  input  wire logic                               wr_en,
  input  wire logic [$clog2(MAX_FRAME_BYTES)-1:0] wr_addr,
  input  wire logic [7:0]                         wr_data,
  input  wire logic                               rd_en,
  input  wire logic [$clog2(MAX_FRAME_BYTES)-1:0] rd_addr,
  output logic      [7:0]                         rd_data
);

  logic [7:0] mem [MAX_FRAME_BYTES];
  logic [7:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> rtl/core/lfgr_frame_ctrl.sv
// ----------------------------------------------------------------------------
// lfgr_frame_ctrl
// Receive-side control: sync hunt, identifier filter, fill count, drop flag
// and the saturating idle counter that closes a frame after a gap.
// ----------------------------------------------------------------------------
`default_nettype none

module lfgr_frame_ctrl #(
  parameter int MAX_FRAME_BYTES = 11
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 item_take,
  input  wire logic                                 item_func,
  input  wire logic [7:0]                           item_byte,
  input  wire logic [7:0]                           expected_id,
  input  wire logic [15:0]                          gap_threshold,
  output logic                                      wr_en,
  output logic      [$clog2(MAX_FRAME_BYTES)-1:0]   wr_addr,
  output logic      [7:0]                           wr_data,
  output logic                                      close_valid,
  output logic      [$clog2(MAX_FRAME_BYTES+1)-1:0] close_len
);

  localparam int AW = $clog2(MAX_FRAME_BYTES);
  localparam int LW = $clog2(MAX_FRAME_BYTES + 1);

  typedef enum logic [1:0] {
    PH_WAIT = 2'b01,
    PH_RECV = 2'b10
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [LW-1:0]   fill_r, fill_nxt;
  logic            drop_r, drop_nxt;
  logic [15:0]     idle_r, idle_nxt;

  // Next-state logic for one accepted request.
  always_comb begin
    phase_nxt   = phase_r;
    fill_nxt    = fill_r;
    drop_nxt    = drop_r;
    idle_nxt    = idle_r;
    wr_en       = 1'b0;
    wr_addr     = fill_r[AW-1:0];
    wr_data     = item_byte;
    close_valid = 1'b0;
    close_len   = fill_r;
    if (item_take) begin
      if (item_func == lfgr_pkg::FUNC_BYTE) begin
        idle_nxt = '0;
        if (phase_r == PH_WAIT) begin
          if (item_byte == lfgr_pkg::SYNC_BYTE) begin
            wr_en     = 1'b1;
            wr_addr   = '0;
            wr_data   = lfgr_pkg::SYNC_BYTE;
            fill_nxt  = LW'(1);
            phase_nxt = PH_RECV;
            drop_nxt  = 1'b0;
          end
        end else if (fill_r == LW'(1) && expected_id != 8'h00 &&
                     item_byte != expected_id) begin
          // Identifier mismatch: drop the frame, restart on a sync byte.
          phase_nxt = PH_WAIT;
          fill_nxt  = '0;
          drop_nxt  = 1'b0;
          if (item_byte == lfgr_pkg::SYNC_BYTE) begin
            wr_en     = 1'b1;
            wr_addr   = '0;
            wr_data   = lfgr_pkg::SYNC_BYTE;
            fill_nxt  = LW'(1);
            phase_nxt = PH_RECV;
          end
        end else if (fill_r < LW'(MAX_FRAME_BYTES)) begin
          wr_en    = 1'b1;
          fill_nxt = fill_r + LW'(1);
        end else begin
          drop_nxt = 1'b1;
        end
      end else if (idle_r != lfgr_pkg::IDLE_MAX) begin
        idle_nxt = idle_r + 16'd1;
      end

      // Gap check after every request while a frame is open.
      if (phase_nxt == PH_RECV && idle_nxt >= gap_threshold) begin
        close_valid = !drop_nxt && (fill_nxt >= LW'(lfgr_pkg::MIN_FRAME_LEN));
        close_len   = fill_nxt;
        phase_nxt   = PH_WAIT;
        fill_nxt    = '0;
        drop_nxt    = 1'b0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      fill_r  <= '0;
      drop_r  <= 1'b0;
      idle_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      fill_r  <= fill_nxt;
      drop_r  <= drop_nxt;
      idle_r  <= idle_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lfgr_readout.sv
// ----------------------------------------------------------------------------
// lfgr_readout
// Readout sequencer: walks the store of a closed frame one byte at a time
// and presents each byte in an output register until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lfgr_readout #(
  parameter int MAX_FRAME_BYTES = 11
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 close_valid,
  input  wire logic [$clog2(MAX_FRAME_BYTES+1)-1:0] close_len,
  output logic                                      rd_en,
  output logic      [$clog2(MAX_FRAME_BYTES)-1:0]   rd_addr,
  input  wire logic [7:0]                           rd_data,
  output logic                                      busy,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output lfgr_pkg::out_beat_t                       out_beat
);

  localparam int AW = $clog2(MAX_FRAME_BYTES);
  localparam int LW = $clog2(MAX_FRAME_BYTES + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_LOAD = 4'b0100,
    S_SHOW = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic [LW-1:0]       len_r, len_nxt;
  lfgr_pkg::out_beat_t beat_r, beat_nxt;
  logic                is_last;
  logic [31:0]         idx_ext;
  logic [31:0]         len_ext;

  assign is_last = (LW'(idx_r) + LW'(1)) == len_r;
  assign idx_ext = 32'(idx_r);
  assign len_ext = 32'(len_r);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    beat_nxt  = beat_r;
    rd_en     = 1'b0;
    rd_addr   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (close_valid) begin
          idx_nxt   = '0;
          len_nxt   = close_len;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        rd_en     = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        beat_nxt.frame_byte   = rd_data;
        beat_nxt.byte_index   = idx_ext[3:0];
        beat_nxt.frame_length = len_ext[3:0];
        beat_nxt.last         = is_last;
        state_nxt             = S_SHOW;
      end
      S_SHOW: begin
        if (!out_stall) begin
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Sequencer state and control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      len_r   <= len_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_SHOW);
  assign out_beat  = beat_r;

endmodule

`default_nettype wire

>>> rtl/core/lin_frame_gap_receiver.sv
// ----------------------------------------------------------------------------
// lin_frame_gap_receiver
// Receives bus bytes and microsecond ticks, assembles a frame that starts at
// the sync byte, and emits the frame byte by byte once the line goes idle.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): each request is a received byte
//   (in_func = 0) or a one-microsecond tick (in_func = 1). One request per
//   cycle is taken while no frame is being read out.
//   When a tick (or byte) brings the idle count to gap_threshold and the
//   frame is good, in_stall rises on the next cycle and stays high until the
//   last byte of the frame has been taken on the output channel.
//   Output channel (out_valid / out_stall): one request per stored byte, in
//   order, with its index, the frame length and a last marker. For each
//   byte the readout reads the store, loads the output register and then
//   shows the byte, holding it while out_stall is high; the next byte is
//   read only after the current one has been taken.
//   Configuration is through the APB-style port: expected_id at 0x0,
//   gap_threshold at 0x4. Write only while the block is idle.
//   Reset (rst_n low, synchronous) returns to sync hunt with empty counters,
//   expected_id = 0 and gap_threshold = 650. The store needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module lin_frame_gap_receiver #(
  parameter int MAX_FRAME_BYTES = 11
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_func,
  input  wire logic [7:0]  in_rx_byte,
  // Result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [7:0]  out_frame_byte,
  output logic      [3:0]  out_byte_index,
  output logic      [3:0]  out_frame_length,
  output logic             out_last,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int AW = $clog2(MAX_FRAME_BYTES);
  localparam int LW = $clog2(MAX_FRAME_BYTES + 1);

  logic [7:0]          expected_id_r, expected_id_nxt;
  logic [15:0]         gap_threshold_r, gap_threshold_nxt;
  logic                cfg_write;
  logic                item_take;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [7:0]          wr_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [7:0]          rd_data;
  logic                close_valid;
  logic [LW-1:0]       close_len;
  logic                busy;
  lfgr_pkg::out_beat_t out_beat;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Register write decode.
  always_comb begin
    expected_id_nxt   = expected_id_r;
    gap_threshold_nxt = gap_threshold_r;
    if (cfg_write) begin
      unique case (paddr[2])
        lfgr_pkg::REG_EXPECTED_ID:   expected_id_nxt   = pwdata[7:0];
        lfgr_pkg::REG_GAP_THRESHOLD: gap_threshold_nxt = pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_id_r   <= 8'h00;
      gap_threshold_r <= lfgr_pkg::GAP_RESET;
    end else begin
      expected_id_r   <= expected_id_nxt;
      gap_threshold_r <= gap_threshold_nxt;
    end
  end

  // Register read mux.
  always_comb begin
    unique case (paddr[2])
      lfgr_pkg::REG_EXPECTED_ID:   prdata = {24'h000000, expected_id_r};
      lfgr_pkg::REG_GAP_THRESHOLD: prdata = {16'h0000, gap_threshold_r};
      default:                     prdata = 32'h00000000;
    endcase
  end

  // Input requests are held off while a frame is being read out.
  assign in_stall  = busy;
  assign item_take = in_valid && !in_stall;

  lfgr_frame_ctrl #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_take    (item_take),
    .item_func    (in_func),
    .item_byte    (in_rx_byte),
    .expected_id  (expected_id_r),
    .gap_threshold(gap_threshold_r),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .close_valid  (close_valid),
    .close_len    (close_len)
  );

  lfgr_store #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  lfgr_readout #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_readout (
    .clk        (clk),
    .rst_n      (rst_n),
    .close_valid(close_valid),
    .close_len  (close_len),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_beat   (out_beat)
  );

  assign out_frame_byte   = out_beat.frame_byte;
  assign out_byte_index   = out_beat.byte_index;
  assign out_frame_length = out_beat.frame_length;
  assign out_last         = out_beat.last;

endmodule

`default_nettype wire
